FILE: hdl/kfn_pkg.sv
// ----------------------------------------------------------------------------
// kfn_pkg
// shared types, constants and key layer tables for the fn layer report builder
// ----------------------------------------------------------------------------
package kfn_pkg;

    localparam int REPORT_SLOTS = 6;
    localparam int KEY_SLOTS    = 6;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CAPS_BEATS   = 3;

    localparam logic [7:0] CAPS_KEY_CODE = 8'h39;
    localparam logic [7:0] CHAR_ONE      = 8'h31;
    localparam logic [7:0] CHAR_BANG     = 8'h21;
    localparam logic [7:0] CHAR_TWO      = 8'h32;
    localparam logic [7:0] CHAR_AT       = 8'h40;

    typedef enum logic
    {
        CMD_REPORT = 1'b0,
        CMD_CAPS   = 1'b1
    } cmd_kind_t;

    typedef logic [KEY_SLOTS-1:0][7:0] key_row_t;

    typedef struct packed
    {
        cmd_kind_t  kind;
        logic [3:0] mods;
        key_row_t   keys;
        logic       caps;
        logic       cursor;
    } cmd_t;

    // {hit, mapped}
    function automatic logic [8:0] fn_lookup(input logic [7:0] code);
        logic [8:0] r;
        case (code)
            8'h35:   r = {1'b1, 8'h29};
            8'h2A:   r = {1'b1, 8'h4C};
            8'h22:   r = {1'b1, 8'h3E};
            8'h23:   r = {1'b1, 8'h3F};
            8'h24:   r = {1'b1, 8'h40};
            8'h25:   r = {1'b1, 8'h41};
            8'h26:   r = {1'b1, 8'h42};
            8'h27:   r = {1'b1, 8'h43};
            8'h31:   r = {1'b1, 8'h49};
            8'h34:   r = {1'b1, 8'h46};
            default: r = {1'b0, code};
        endcase
        return r;
    endfunction

    function automatic logic [8:0] nav_lookup(input logic [7:0] code);
        logic [8:0] r;
        case (code)
            8'h33:   r = {1'b1, 8'h52};
            8'h37:   r = {1'b1, 8'h51};
            8'h36:   r = {1'b1, 8'h50};
            8'h38:   r = {1'b1, 8'h4F};
            8'h2d:   r = {1'b1, 8'h4A};
            8'h2f:   r = {1'b1, 8'h4D};
            8'h2e:   r = {1'b1, 8'h4B};
            8'h30:   r = {1'b1, 8'h4E};
            default: r = {1'b0, code};
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/kfn_front.sv
// ----------------------------------------------------------------------------
// kfn_front
// accepts key events, keeps the caps and cursor flags, classifies and remaps
// ----------------------------------------------------------------------------
module kfn_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [3:0]          modifier_flags,
    input  logic                fn_held,
    input  logic                has_char,
    input  logic [7:0]          first_char,
    input  logic [3:0]          key_count,
    input  kfn_pkg::key_row_t   scan_codes,
    output logic                cmd_valid,
    input  logic                cmd_stall,
    output kfn_pkg::cmd_t       cmd
);

    logic caps_reg;
    logic caps_next;
    logic cursor_reg;
    logic cursor_next;
    logic accept;
    logic is_caps;
    logic is_cursor;
    logic blank;
    logic [8:0] fn_hit;
    logic [8:0] nav_hit;
    kfn_pkg::key_row_t mapped;

    assign accept    = in_valid && !cmd_stall;
    assign in_stall  = cmd_stall;
    assign cmd_valid = in_valid;

    assign is_caps   = !mode && fn_held && has_char
                       && (first_char == kfn_pkg::CHAR_ONE || first_char == kfn_pkg::CHAR_BANG);
    assign is_cursor = !mode && fn_held && has_char
                       && (first_char == kfn_pkg::CHAR_TWO || first_char == kfn_pkg::CHAR_AT);
    assign blank     = mode || is_caps || is_cursor;

    always_comb
    begin
        mapped  = '0;
        fn_hit  = '0;
        nav_hit = '0;
        for (int i = 0; i < kfn_pkg::REPORT_SLOTS; i++)
        begin
            fn_hit  = kfn_pkg::fn_lookup(scan_codes[i]);
            nav_hit = kfn_pkg::nav_lookup(scan_codes[i]);
            if (4'(i) < key_count)
            begin
                if (fn_held)
                begin
                    mapped[i] = fn_hit[8] ? fn_hit[7:0] : nav_hit[7:0];
                end
                else if (cursor_reg)
                begin
                    mapped[i] = nav_hit[7:0];
                end
                else
                begin
                    mapped[i] = scan_codes[i];
                end
            end
        end
    end

    always_comb
    begin
        cmd.kind   = is_caps ? kfn_pkg::CMD_CAPS : kfn_pkg::CMD_REPORT;
        cmd.mods   = blank ? 4'd0 : modifier_flags;
        cmd.keys   = blank ? '0 : mapped;
        cmd.caps   = caps_reg ^ is_caps;
        cmd.cursor = cursor_reg ^ is_cursor;
    end

    assign caps_next   = caps_reg ^ (accept && is_caps);
    assign cursor_next = cursor_reg ^ (accept && is_cursor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_reg   <= 1'b0;
            cursor_reg <= 1'b0;
        end
        else
        begin
            caps_reg   <= caps_next;
            cursor_reg <= cursor_next;
        end
    end

endmodule

FILE: hdl/kfn_queue.sv
// ----------------------------------------------------------------------------
// kfn_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module kfn_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_stall,
    input  kfn_pkg::cmd_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_stall,
    output kfn_pkg::cmd_t  rd_data
);

    localparam int PTR_W = $clog2(kfn_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(kfn_pkg::QUEUE_DEPTH + 1);

    kfn_pkg::cmd_t slot_reg [kfn_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic push;
    logic pop;

    assign wr_stall = (count_reg == CNT_W'(kfn_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(kfn_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(kfn_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/kfn_back.sv
// ----------------------------------------------------------------------------
// kfn_back
// expands commands into report beats and holds the output register
// ----------------------------------------------------------------------------
module kfn_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  kfn_pkg::cmd_t       cmd,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          report_modifiers,
    output kfn_pkg::key_row_t   report_keys,
    output logic                caps_lock_on,
    output logic                cursor_mode_on,
    output logic                last_of_run
);

    localparam int BEAT_W = $clog2(kfn_pkg::CAPS_BEATS);

    kfn_pkg::cmd_t    cur_reg;
    logic             valid_reg;
    logic             valid_next;
    logic [BEAT_W-1:0] beat_reg;
    logic [BEAT_W-1:0] beat_next;
    logic fire;
    logic last;
    logic load;
    logic is_caps;

    assign is_caps   = (cur_reg.kind == kfn_pkg::CMD_CAPS);
    assign last      = !is_caps || (beat_reg == BEAT_W'(kfn_pkg::CAPS_BEATS - 1));
    assign fire      = valid_reg && !out_stall;
    assign load      = cmd_valid && (!valid_reg || (fire && last));
    assign cmd_stall = !(!valid_reg || (fire && last));

    always_comb
    begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load)
        begin
            valid_next = 1'b1;
            beat_next  = '0;
        end
        else if (fire && !last)
        begin
            beat_next = beat_reg + BEAT_W'(1);
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_comb
    begin
        report_keys = cur_reg.keys;
        if (is_caps)
        begin
            report_keys = '0;
            if (beat_reg == '0)
            begin
                report_keys[0] = kfn_pkg::CAPS_KEY_CODE;
            end
        end
    end

    assign out_valid        = valid_reg;
    assign report_modifiers = cur_reg.mods;
    assign caps_lock_on     = cur_reg.caps;
    assign cursor_mode_on   = cur_reg.cursor;
    assign last_of_run      = last;

endmodule

FILE: hdl/keyboard_fn_layer_hid_report_builder_top.sv
// ----------------------------------------------------------------------------
// keyboard_fn_layer_hid_report_builder_top
// builds hid keyboard reports from key events with an fn layer
//
//   channel   direction  handshake            beat
//   events    in         in_valid / in_stall  one key event
//   reports   out        out_valid / out_stall one hid report
//
// an ordinary event gives one report and the block takes one event per cycle while the queue is not full
// a caps lock toggle gives three reports from the back end
// a two-entry queue lets events enter while the back end plays out a toggle
// rst_n clears both flags, the queue and the output valid flag at once
// ----------------------------------------------------------------------------
module keyboard_fn_layer_hid_report_builder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       mode,
    input  logic [3:0] modifier_flags,
    input  logic       fn_held,
    input  logic       has_char,
    input  logic [7:0] first_char,
    input  logic [3:0] key_count,
    input  logic [7:0] scan_code_0,
    input  logic [7:0] scan_code_1,
    input  logic [7:0] scan_code_2,
    input  logic [7:0] scan_code_3,
    input  logic [7:0] scan_code_4,
    input  logic [7:0] scan_code_5,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] report_modifiers,
    output logic [7:0] report_key_0,
    output logic [7:0] report_key_1,
    output logic [7:0] report_key_2,
    output logic [7:0] report_key_3,
    output logic [7:0] report_key_4,
    output logic [7:0] report_key_5,
    output logic       caps_lock_on,
    output logic       cursor_mode_on,
    output logic       last_of_run
);

    kfn_pkg::key_row_t scan_codes;
    kfn_pkg::key_row_t report_keys;
    kfn_pkg::cmd_t     front_cmd;
    kfn_pkg::cmd_t     back_cmd;
    logic front_valid;
    logic front_stall;
    logic back_valid;
    logic back_stall;

    assign scan_codes[0] = scan_code_0;
    assign scan_codes[1] = scan_code_1;
    assign scan_codes[2] = scan_code_2;
    assign scan_codes[3] = scan_code_3;
    assign scan_codes[4] = scan_code_4;
    assign scan_codes[5] = scan_code_5;

    kfn_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .modifier_flags (modifier_flags),
        .fn_held        (fn_held),
        .has_char       (has_char),
        .first_char     (first_char),
        .key_count      (key_count),
        .scan_codes     (scan_codes),
        .cmd_valid      (front_valid),
        .cmd_stall      (front_stall),
        .cmd            (front_cmd)
    );

    kfn_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_stall (front_stall),
        .wr_data  (front_cmd),
        .rd_valid (back_valid),
        .rd_stall (back_stall),
        .rd_data  (back_cmd)
    );

    kfn_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (back_valid),
        .cmd_stall        (back_stall),
        .cmd              (back_cmd),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .report_modifiers (report_modifiers),
        .report_keys      (report_keys),
        .caps_lock_on     (caps_lock_on),
        .cursor_mode_on   (cursor_mode_on),
        .last_of_run      (last_of_run)
    );

    assign report_key_0 = report_keys[0];
    assign report_key_1 = report_keys[1];
    assign report_key_2 = report_keys[2];
    assign report_key_3 = report_keys[3];
    assign report_key_4 = report_keys[4];
    assign report_key_5 = report_keys[5];

endmodule

FILE: hdl/kfn_checker.sv
// ----------------------------------------------------------------------------
// kfn_checker
// port level checks on report runs, bound to the top level
// ----------------------------------------------------------------------------
module kfn_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] report_modifiers,
    input logic       caps_lock_on,
    input logic       cursor_mode_on,
    input logic       last_of_run
);

    // a stalled beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("report beat withdrawn while stalled");

    // the rest of a run follows without a gap
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside a report run");

    // flags stay fixed within one run
    a_run_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run
        |=> $stable(caps_lock_on) && $stable(cursor_mode_on))
        else $error("flags changed inside a report run");

    // only toggle runs have more than one beat, and those carry no modifiers
    a_run_mods: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> report_modifiers == 4'd0)
        else $error("modifiers on a toggle report");

endmodule

bind keyboard_fn_layer_hid_report_builder_top kfn_checker u_kfn_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .report_modifiers (report_modifiers),
    .caps_lock_on     (caps_lock_on),
    .cursor_mode_on   (cursor_mode_on),
    .last_of_run      (last_of_run)
);

FILE: verif/keyboard_fn_layer_hid_report_builder_checker.sv
// ----------------------------------------------------------------------------
// keyboard_fn_layer_hid_report_builder_checker
// watches the event and report channels, works out the reports that each
// accepted event must give from its own copy of the caps lock and cursor
// flags, and compares every accepted report field by field in order
// ----------------------------------------------------------------------------
module keyboard_fn_layer_hid_report_builder_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       mode,
    input  logic [3:0] modifier_flags,
    input  logic       fn_held,
    input  logic       has_char,
    input  logic [7:0] first_char,
    input  logic [3:0] key_count,
    input  logic [7:0] scan_code_0,
    input  logic [7:0] scan_code_1,
    input  logic [7:0] scan_code_2,
    input  logic [7:0] scan_code_3,
    input  logic [7:0] scan_code_4,
    input  logic [7:0] scan_code_5,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [3:0] report_modifiers,
    input  logic [7:0] report_key_0,
    input  logic [7:0] report_key_1,
    input  logic [7:0] report_key_2,
    input  logic [7:0] report_key_3,
    input  logic [7:0] report_key_4,
    input  logic [7:0] report_key_5,
    input  logic       caps_lock_on,
    input  logic       cursor_mode_on,
    input  logic       last_of_run,
    output int         fail_count,
    output int         pending_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic EV_RELEASE = 1'b1;

    typedef struct packed
    {
        logic [3:0]          mods;
        kfn_pkg::key_row_t   keys;
        logic                caps;
        logic                cursor;
        logic                last;
    } hid_report_t;

    hid_report_t         expected_reports[$];
    hid_report_t         oldest;
    hid_report_t         predicted;
    kfn_pkg::key_row_t   held_codes;
    kfn_pkg::key_row_t   seen_keys;
    logic        caps_flag = 1'b0;
    logic        cursor_flag = 1'b0;
    logic        caps_toggle;
    logic        cursor_toggle;
    logic [7:0]  code;
    logic [7:0]  mapped;
    int          slots;
    int          mismatches = 0;
    int          queued = 0;

    assign held_codes = {scan_code_5, scan_code_4, scan_code_3,
                         scan_code_2, scan_code_1, scan_code_0};
    assign seen_keys  = {report_key_5, report_key_4, report_key_3,
                         report_key_2, report_key_1, report_key_0};
    assign fail_count      = mismatches;
    assign pending_reports = queued;

    task automatic report_failure(input string text);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch: %s", $time, text);
    endtask

    task automatic check_field(input string name, input logic [7:0] expv,
                               input logic [7:0] actv);
        if (actv !== expv)
            report_failure($sformatf("%s expected %0h got %0h", name, expv, actv));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_flag   = 1'b0;
            cursor_flag = 1'b0;
            expected_reports.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                    report_failure("report beat with none expected");
                else
                begin
                    oldest = expected_reports.pop_front();
                    check_field("report_modifiers", 8'(oldest.mods), 8'(report_modifiers));
                    for (int i = 0; i < kfn_pkg::KEY_SLOTS; i++)
                        check_field($sformatf("report_key_%0d", i), oldest.keys[i],
                                    seen_keys[i]);
                    check_field("caps_lock_on", 8'(oldest.caps), 8'(caps_lock_on));
                    check_field("cursor_mode_on", 8'(oldest.cursor), 8'(cursor_mode_on));
                    check_field("last_of_run", 8'(oldest.last), 8'(last_of_run));
                end
            end

            if (in_valid && !in_stall)
            begin
                caps_toggle   = (mode != EV_RELEASE) && fn_held && has_char &&
                                (first_char == kfn_pkg::CHAR_ONE ||
                                 first_char == kfn_pkg::CHAR_BANG);
                cursor_toggle = (mode != EV_RELEASE) && fn_held && has_char &&
                                (first_char == kfn_pkg::CHAR_TWO ||
                                 first_char == kfn_pkg::CHAR_AT);
                if (caps_toggle)
                    caps_flag = ~caps_flag;
                if (cursor_toggle)
                    cursor_flag = ~cursor_flag;

                predicted        = '0;
                predicted.caps   = caps_flag;
                predicted.cursor = cursor_flag;
                predicted.last   = 1'b1;

                if (caps_toggle)
                begin
                    predicted.last    = 1'b0;
                    predicted.keys[0] = kfn_pkg::CAPS_KEY_CODE;
                    expected_reports.push_back(predicted);
                    predicted.keys[0] = 8'h00;
                    expected_reports.push_back(predicted);
                    predicted.last    = 1'b1;
                end
                else if (mode != EV_RELEASE && !cursor_toggle)
                begin
                    predicted.mods = modifier_flags;
                    slots = (int'(key_count) > kfn_pkg::REPORT_SLOTS)
                            ? kfn_pkg::REPORT_SLOTS : int'(key_count);
                    if (slots > kfn_pkg::KEY_SLOTS)
                        slots = kfn_pkg::KEY_SLOTS;
                    for (int i = 0; i < slots; i++)
                    begin
                        code   = held_codes[i];
                        mapped = code;
                        if (fn_held)
                        begin
                            case (code)
                                8'h35:   mapped = 8'h29;
                                8'h2A:   mapped = 8'h4C;
                                8'h22:   mapped = 8'h3E;
                                8'h23:   mapped = 8'h3F;
                                8'h24:   mapped = 8'h40;
                                8'h25:   mapped = 8'h41;
                                8'h26:   mapped = 8'h42;
                                8'h27:   mapped = 8'h43;
                                8'h31:   mapped = 8'h49;
                                8'h34:   mapped = 8'h46;
                                default: mapped = code;
                            endcase
                        end
                        // navigation layer: fn miss, or cursor mode without fn
                        if ((fn_held || cursor_flag) && mapped == code)
                        begin
                            case (code)
                                8'h33:   mapped = 8'h52;
                                8'h37:   mapped = 8'h51;
                                8'h36:   mapped = 8'h50;
                                8'h38:   mapped = 8'h4F;
                                8'h2d:   mapped = 8'h4A;
                                8'h2f:   mapped = 8'h4D;
                                8'h2e:   mapped = 8'h4B;
                                8'h30:   mapped = 8'h4E;
                                default: mapped = code;
                            endcase
                        end
                        predicted.keys[i] = mapped;
                    end
                end
                expected_reports.push_back(predicted);
            end
        end
        queued = expected_reports.size();
    end

endmodule

FILE: verif/keyboard_fn_layer_hid_report_builder_top_test.sv
// ----------------------------------------------------------------------------
// keyboard_fn_layer_hid_report_builder_top_test
// drives key events into the report builder, directed cases first and then
// random bursts with random gaps, while the report side stalls on patterns of
// its own; the checker beside the block predicts and compares every report
// ----------------------------------------------------------------------------
module keyboard_fn_layer_hid_report_builder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic EV_HELD     = 1'b0;
    localparam logic EV_RELEASE  = 1'b1;
    localparam int   RANDOM_EVENTS  = 420;
    localparam int   WATCHDOG_LIMIT = 4000;

    localparam logic [7:0] LAYER_CODES [20] = '{
        8'h35, 8'h2A, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h31, 8'h34,
        8'h33, 8'h37, 8'h36, 8'h38, 8'h2d, 8'h2f, 8'h2e, 8'h30, 8'h00, 8'hFF
    };

    typedef enum int
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    typedef struct packed
    {
        logic              mode;
        logic [3:0]        mods;
        logic              fn;
        logic              has_char;
        logic [7:0]        ch;
        logic [3:0]        count;
        kfn_pkg::key_row_t codes;
    } key_event_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       mode;
    logic [3:0] modifier_flags;
    logic       fn_held;
    logic       has_char;
    logic [7:0] first_char;
    logic [3:0] key_count;
    logic [7:0] scan_code_0;
    logic [7:0] scan_code_1;
    logic [7:0] scan_code_2;
    logic [7:0] scan_code_3;
    logic [7:0] scan_code_4;
    logic [7:0] scan_code_5;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] report_modifiers;
    logic [7:0] report_key_0;
    logic [7:0] report_key_1;
    logic [7:0] report_key_2;
    logic [7:0] report_key_3;
    logic [7:0] report_key_4;
    logic [7:0] report_key_5;
    logic       caps_lock_on;
    logic       cursor_mode_on;
    logic       last_of_run;
    int         fail_count;
    int         pending_reports;

    stall_style_t stall_style = STALL_NONE;
    int           style_left = 0;
    int           stall_phase = 0;
    int           idle_cycles = 0;

    keyboard_fn_layer_hid_report_builder_top DUT (.*);

    keyboard_fn_layer_hid_report_builder_checker report_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // report side stall patterns
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(10, 60);
        end
        else
            style_left--;
        stall_phase++;
        case (stall_style)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
            STALL_TOGGLE: out_stall <= stall_phase[1];
            default:      out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic key_event_t held_event(input logic [3:0] mods, input logic fn,
                                              input logic has_ch, input logic [7:0] ch,
                                              input logic [3:0] count,
                                              input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic [7:0] c3,
                                              input logic [7:0] c4, input logic [7:0] c5);
        key_event_t ev;
        ev.mode     = EV_HELD;
        ev.mods     = mods;
        ev.fn       = fn;
        ev.has_char = has_ch;
        ev.ch       = ch;
        ev.count    = count;
        ev.codes[0] = c0;
        ev.codes[1] = c1;
        ev.codes[2] = c2;
        ev.codes[3] = c3;
        ev.codes[4] = c4;
        ev.codes[5] = c5;
        return ev;
    endfunction

    function automatic key_event_t random_event();
        key_event_t ev;
        int         pick;
        ev.mode     = ($urandom_range(0, 9) == 0) ? EV_RELEASE : EV_HELD;
        ev.mods     = 4'($urandom_range(0, 15));
        ev.fn       = ($urandom_range(0, 9) < 4);
        ev.has_char = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        case (pick)
            0:       ev.ch = kfn_pkg::CHAR_ONE;
            1:       ev.ch = kfn_pkg::CHAR_BANG;
            2:       ev.ch = kfn_pkg::CHAR_TWO;
            3:       ev.ch = kfn_pkg::CHAR_AT;
            default: ev.ch = 8'($urandom_range(0, 255));
        endcase
        ev.count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(7, 15))
                                               : 4'($urandom_range(0, 6));
        for (int i = 0; i < kfn_pkg::KEY_SLOTS; i++)
        begin
            if ($urandom_range(0, 1))
                ev.codes[i] = LAYER_CODES[$urandom_range(0, 19)];
            else
                ev.codes[i] = 8'($urandom_range(0, 255));
        end
        return ev;
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic drive_event(input key_event_t ev);
        in_valid       <= 1'b1;
        mode           <= ev.mode;
        modifier_flags <= ev.mods;
        fn_held        <= ev.fn;
        has_char       <= ev.has_char;
        first_char     <= ev.ch;
        key_count      <= ev.count;
        scan_code_0    <= ev.codes[0];
        scan_code_1    <= ev.codes[1];
        scan_code_2    <= ev.codes[2];
        scan_code_3    <= ev.codes[3];
        scan_code_4    <= ev.codes[4];
        scan_code_5    <= ev.codes[5];
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_reports_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_reports != 0);
    endtask

    initial
    begin
        key_event_t ev;
        int         burst_left;
        int         gap;

        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        mode           = EV_HELD;
        modifier_flags = 4'h0;
        fn_held        = 1'b0;
        has_char       = 1'b0;
        first_char     = 8'h00;
        key_count      = 4'h0;
        scan_code_0    = 8'h00;
        scan_code_1    = 8'h00;
        scan_code_2    = 8'h00;
        scan_code_3    = 8'h00;
        scan_code_4    = 8'h00;
        scan_code_5    = 8'h00;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // release ignores everything else, even an fn toggle character
        ev = held_event(4'hF, 1'b1, 1'b1, kfn_pkg::CHAR_ONE, 4'hF,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        ev.mode = EV_RELEASE;
        drive_event(ev);
        drive_event(held_event(4'hF, 1'b0, 1'b0, 8'h00, 4'h0,
                               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        drive_event(held_event(4'h0, 1'b0, 1'b0, 8'hFF, 4'h6,
                               8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE));
        drive_event(held_event(4'hA, 1'b0, 1'b1, 8'h61, 4'hF,
                               8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        drive_event(held_event(4'h5, 1'b1, 1'b1, kfn_pkg::CHAR_ONE, 4'h2,
                               8'h35, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00));
        ev.mods = 4'h3;
        drive_event(ev);
        drive_event(held_event(4'h0, 1'b1, 1'b1, kfn_pkg::CHAR_BANG, 4'h0,
                               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        drive_event(held_event(4'h1, 1'b1, 1'b1, kfn_pkg::CHAR_TWO, 4'h3,
                               8'h33, 8'h37, 8'h35, 8'h00, 8'h00, 8'h00));
        drive_event(held_event(4'h2, 1'b0, 1'b0, 8'h00, 4'h6,
                               8'h33, 8'h37, 8'h36, 8'h38, 8'h2d, 8'h2f));
        drive_event(held_event(4'h4, 1'b0, 1'b0, 8'h00, 4'h6,
                               8'h2e, 8'h30, 8'h35, 8'h2A, 8'h22, 8'hFF));
        drive_event(held_event(4'h8, 1'b1, 1'b0, 8'h00, 4'h6,
                               8'h35, 8'h2A, 8'h22, 8'h23, 8'h24, 8'h25));
        drive_event(held_event(4'h9, 1'b1, 1'b1, 8'h61, 4'h6,
                               8'h26, 8'h27, 8'h31, 8'h34, 8'h33, 8'h37));
        drive_event(held_event(4'h6, 1'b1, 1'b0, kfn_pkg::CHAR_ONE, 4'h6,
                               8'h36, 8'h38, 8'h2d, 8'h2f, 8'h2e, 8'h30));
        drive_event(held_event(4'h7, 1'b0, 1'b1, kfn_pkg::CHAR_ONE, 4'h4,
                               8'h33, 8'h35, 8'h30, 8'h31, 8'h00, 8'h00));
        drive_event(held_event(4'hC, 1'b1, 1'b1, kfn_pkg::CHAR_AT, 4'h6,
                               8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33));
        drive_event(held_event(4'h3, 1'b0, 1'b0, 8'h00, 4'h2,
                               8'h33, 8'h37, 8'h00, 8'h00, 8'h00, 8'h00));
        drive_event(held_event(4'h8, 1'b1, 1'b1, 8'h41, 4'h0,
                               8'h35, 8'h35, 8'h35, 8'h35, 8'h35, 8'h35));
        drive_event(held_event(4'hF, 1'b1, 1'b1, kfn_pkg::CHAR_ONE, 4'h6,
                               8'h35, 8'h2A, 8'h22, 8'h23, 8'h24, 8'h25));
        drive_event(held_event(4'h0, 1'b1, 1'b1, kfn_pkg::CHAR_TWO, 4'h0,
                               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        drive_event(held_event(4'hE, 1'b0, 1'b0, 8'h00, 4'h7,
                               8'h38, 8'h2d, 8'h26, 8'h2f, 8'h2e, 8'h30));
        drive_event(held_event(4'h0, 1'b1, 1'b1, kfn_pkg::CHAR_BANG, 4'h1,
                               8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        drive_event(held_event(4'h0, 1'b1, 1'b1, kfn_pkg::CHAR_AT, 4'h1,
                               8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_reports_drained();

        burst_left = 0;
        for (int n = 0; n < RANDOM_EVENTS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
                gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            drive_event(random_event());
            burst_left--;
            if (n % 150 == 149)
            begin
                wait_reports_drained();
                burst_left = 0;
            end
        end

        wait_reports_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_reports == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
